// ----- rtl/smpq_pkg.sv -----
`timescale 1ns / 1ps

package smpq_pkg;

    // Widths of the word fields.
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Value returned by dequeue or peek on an empty queue.
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    // Action codes of an input word.
    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PEEK = 2'd2
    } t_action;

    // Status codes of a result word.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic                     ins;
        logic                     pop;
        logic signed [DATA_W-1:0] key;
    } t_cell_ctl;

endpackage

// ----- rtl/smpq_cell.sv -----
`timescale 1ns / 1ps

module smpq_cell (
    input  logic                                 i_clk,
    input  smpq_pkg::t_cell_ctl                  i_ctl,
    input  logic                                 i_occupied,
    input  logic                                 i_at_tail,
    input  logic                                 i_left_gt,
    input  logic signed [smpq_pkg::DATA_W-1:0]   i_left_value,
    input  logic signed [smpq_pkg::DATA_W-1:0]   i_right_value,
    output logic                                 o_gt,
    output logic signed [smpq_pkg::DATA_W-1:0]   o_value
);

    logic signed [smpq_pkg::DATA_W-1:0] r_value;
    logic signed [smpq_pkg::DATA_W-1:0] n_value;

    // This cell holds a value larger than the key, so the key goes at or before it.
    assign o_gt    = i_occupied && (r_value > i_ctl.key);
    assign o_value = r_value;

    // On insert the larger values move one cell toward the tail; on pop all move
    // one cell toward the head.
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_value = i_left_value;
            end else if (o_gt || i_at_tail) begin
                n_value = i_ctl.key;
            end
        end else if (i_ctl.pop) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- rtl/sorted_min_priority_queue.sv -----
`timescale 1ns / 1ps
// Sorted priority queue of signed 32-bit values, smallest value served first.
// Input channel: i_in_valid / o_in_stall carry one word of i_action and i_value.
// Action enqueue inserts i_value in sorted order, dequeue removes and returns
// the smallest value, peek returns it and leaves it stored. Action code 3 does
// nothing and returns status ok.
// Output channel: o_out_valid / i_out_stall carry one result word per input word
// (o_result_value, o_status, o_occupancy).
// The values sit in a row of DEPTH cells; all cells compare against the new
// value at once and shift by one place.
// o_out_valid rises in the cycle after acceptance, and a new word can be
// accepted every cycle while the result register is free or being taken.
// When the receiver stalls, the result register holds its word and o_in_stall
// rises until that word is taken.
// Reset empties the queue (count to zero) and drops any pending result; the
// cell contents are not cleared, since entries past the count are never read.
module sorted_min_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_action,
    input  logic signed [smpq_pkg::DATA_W-1:0]   i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [smpq_pkg::DATA_W-1:0]   o_result_value,
    output logic [smpq_pkg::STAT_W-1:0]          o_status,
    output logic [smpq_pkg::OCC_W-1:0]           o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]                        r_count;
    logic [CW-1:0]                        n_count;
    logic                                 r_out_valid;
    logic signed [smpq_pkg::DATA_W-1:0]   r_out_value;
    logic signed [smpq_pkg::DATA_W-1:0]   n_out_value;
    logic [smpq_pkg::STAT_W-1:0]          r_out_status;
    logic [smpq_pkg::STAT_W-1:0]          n_out_status;
    logic [smpq_pkg::OCC_W-1:0]           r_out_occ;
    logic [CW+smpq_pkg::OCC_W-1:0]        w_occ_ext;

    logic                                 w_accept;
    logic                                 w_full;
    logic                                 w_empty;
    smpq_pkg::t_cell_ctl                  w_ctl;

    logic                                 w_gt    [0:DEPTH];
    logic signed [smpq_pkg::DATA_W-1:0]   w_value [0:DEPTH];

    // Handshake: the result register frees when its word is taken.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Control broadcast to the cell row.
    always_comb begin
        w_ctl     = '0;
        w_ctl.key = i_value;
        if (w_accept) begin
            w_ctl.ins = (i_action == smpq_pkg::ACT_ENQ) && !w_full;
            w_ctl.pop = (i_action == smpq_pkg::ACT_DEQ) && !w_empty;
        end
    end

    // Row ends: nothing larger sits before the head, nothing follows the tail.
    assign w_gt[0]        = 1'b0;
    assign w_value[DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                               w_left_gt;
            logic signed [smpq_pkg::DATA_W-1:0] w_left_value;
            logic signed [smpq_pkg::DATA_W-1:0] w_cell_value;

            assign w_left_gt    = w_gt[gi];
            assign w_left_value = (gi == 0) ? '0 : w_value[(gi == 0) ? 0 : gi - 1];
            assign w_value[gi]  = w_cell_value;

            smpq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occupied    (CW'(gi) < r_count),
                .i_at_tail     (CW'(gi) == r_count),
                .i_left_gt     (w_left_gt),
                .i_left_value  (w_left_value),
                .i_right_value (w_value[gi+1]),
                .o_gt          (w_gt[gi+1]),
                .o_value       (w_cell_value)
            );
        end
    endgenerate

    // Result word and new count for the accepted action.
    always_comb begin
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = smpq_pkg::ST_OK;
        case (smpq_pkg::t_action'(i_action))
            smpq_pkg::ACT_ENQ: begin
                if (w_full) begin
                    n_out_status = smpq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            smpq_pkg::ACT_DEQ, smpq_pkg::ACT_PEEK: begin
                if (w_empty) begin
                    n_out_value  = smpq_pkg::EMPTY_VALUE;
                    n_out_status = smpq_pkg::ST_EMPTY;
                end else begin
                    n_out_value = w_value[0];
                    if (i_action == smpq_pkg::ACT_DEQ) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Occupancy is reported modulo 32.
    assign w_occ_ext = {{smpq_pkg::OCC_W{1'b0}}, n_count};

    // Count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_occ    <= w_occ_ext[smpq_pkg::OCC_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_occupancy    = r_out_occ;

endmodule

// ----- rtl/smpq_checker.sv -----
`timescale 1ns / 1ps

module smpq_port_checker #(
    parameter int DEPTH = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [smpq_pkg::DATA_W-1:0]   o_result_value,
    input logic [smpq_pkg::STAT_W-1:0]          o_status,
    input logic [smpq_pkg::OCC_W-1:0]           o_occupancy
);

    localparam int DW = 32;
    localparam logic [DW-1:0] DEPTH_W = DEPTH;

    // A stalled result word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_status) && $stable(o_occupancy))
        else $error("stalled result word changed");

    // An empty status always comes with value -1 and zero occupancy.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == smpq_pkg::ST_EMPTY |->
            o_result_value == smpq_pkg::EMPTY_VALUE && o_occupancy == '0)
        else $error("empty status with wrong value or occupancy");

    // A dropped insert means the queue holds DEPTH values.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == smpq_pkg::ST_FULL |->
            o_occupancy == DEPTH_W[smpq_pkg::OCC_W-1:0] && o_result_value == '0)
        else $error("full status with wrong occupancy");

    // An accepted word gives a result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted word produced no result");

    // No result is shown right after reset.
    a_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_min_priority_queue smpq_port_checker #(.DEPTH(DEPTH)) u_smpq_checker (.*);
